@@ rtl/pawg_pkg.sv @@
// Shared types, register codes and waveform shaping functions for the phase oscillator.
package pawg_pkg;

  localparam int unsigned PhaseW   = 32;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ShapeW   = 2;
  localparam int unsigned PulseW   = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PhaseW-1:0]  HalfScale = 32'h8000_0000;
  localparam logic [SampleW-1:0] SampleMax = 16'h7FFF;
  localparam logic [SampleW-1:0] SampleMin = 16'h8000;

  // Waveform codes; the unused code renders saw
  typedef enum logic [ShapeW-1:0] {
    SHAPE_SAW      = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2
  } shape_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WAVE_SHAPE  = 2'd0,
    REG_PULSE_WIDTH = 2'd1,
    REG_PHASE_INCR  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ShapeW-1:0] wave_shape;
    logic [PulseW-1:0] pulse_width;
    logic [PhaseW-1:0] phase_step;
  } cfg_t;

  // One beat between the accumulator and the shaper
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              block_end;
  } beat_t;

  // Saw: top half of the phase, offset to signed
  function automatic logic [SampleW-1:0] shape_saw(input logic [PhaseW-1:0] ph);
    return ph[PhaseW-1 -: SampleW] ^ SampleMin;
  endfunction

  // Square: high below the threshold, low at or above it
  function automatic logic [SampleW-1:0] shape_square(input logic [PhaseW-1:0] ph,
                                                       input logic [PulseW-1:0] pw);
    logic [PhaseW-1:0] thr;
    thr = HalfScale + {1'b0, pw, 16'h0000};
    return (ph < thr) ? SampleMax : SampleMin;
  endfunction

  // Triangle: fold phase>>15 about its midpoint, then offset to signed
  function automatic logic [SampleW-1:0] shape_triangle(input logic [PhaseW-1:0] ph);
    logic [SampleW:0]   t;
    logic [SampleW-1:0] f;
    t = ph[PhaseW-1 -: SampleW+1];
    f = t[SampleW] ? ~t[SampleW-1:0] : t[SampleW-1:0];
    return f ^ SampleMin;
  endfunction

endpackage

@@ rtl/pawg_cfg.sv @@
// Configuration register file: waveform shape, pulse width and phase increment.
module pawg_cfg
  import pawg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; drop writes to unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WAVE_SHAPE:  cfg_d.wave_shape  = cfg_data_i[ShapeW-1:0];
        REG_PULSE_WIDTH: cfg_d.pulse_width = cfg_data_i[PulseW-1:0];
        REG_PHASE_INCR:  cfg_d.phase_step  = cfg_data_i[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pawg_accum.sv @@
// Phase accumulator stage: sync clear, increment with wrap, beat register.
module pawg_accum
  import pawg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              sync_reset_i,
  input  logic              block_end_in_i,
  input  logic [PhaseW-1:0] phase_step_i,
  input  logic              take_i,
  output logic              beat_valid_o,
  output beat_t             beat_o
);

  beat_t             beat_q, beat_d;
  logic              valid_q, valid_d;
  logic              accept;
  logic [PhaseW-1:0] base;

  // Take a new beat when empty or when the current one moves on
  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clear on sync, then advance by the increment
  assign base = sync_reset_i ? '0 : beat_q.phase;

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q;
    if (accept) begin
      beat_d.phase     = base + phase_step_i;
      beat_d.block_end = block_end_in_i;
      valid_d          = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // Phase lives in the beat register and resets to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

@@ rtl/pawg_shaper.sv @@
// Waveform shaper and output register with valid/stall handshake.
module pawg_shaper
  import pawg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_valid_i,
  input  beat_t              beat_i,
  input  cfg_t               cfg_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SampleW-1:0] sample_o,
  output logic               block_end_out_o
);

  logic               valid_q, valid_d;
  logic [SampleW-1:0] sample_q, sample_d;
  logic               blk_q, blk_d;
  logic               room;
  logic [SampleW-1:0] shaped;

  // Output register frees up when empty or when its beat is taken
  assign room   = !valid_q || !out_stall_i;
  assign take_o = beat_valid_i && room;

  // Select the waveform
  always_comb begin
    case (shape_e'(cfg_i.wave_shape))
      SHAPE_SQUARE:   shaped = shape_square(beat_i.phase, cfg_i.pulse_width);
      SHAPE_TRIANGLE: shaped = shape_triangle(beat_i.phase);
      default:        shaped = shape_saw(beat_i.phase);
    endcase
  end

  // Load on take, drop valid once delivered, hold while stalled
  always_comb begin
    valid_d  = valid_q;
    sample_d = sample_q;
    blk_d    = blk_q;
    if (take_o) begin
      valid_d  = 1'b1;
      sample_d = shaped;
      blk_d    = beat_i.block_end;
    end else if (room) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    blk_q    <= blk_d;
  end

  assign out_valid_o     = valid_q;
  assign sample_o        = sample_q;
  assign block_end_out_o = blk_q;

endmodule

@@ rtl/phase_accumulator_waveform_gen.sv @@
// Phase accumulator oscillator: top level joining config, accumulator and shaper.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample tick per beat with
//   sync_reset_i (clear phase before this tick's add) and block_end_in_i.
//   Output channel (out_valid_o / out_stall_i) returns one signed 16-bit sample_o
//   per input beat, with block_end_in_i copied as block_end_out_o.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 wave shape, 1 pulse
//   width, 2 phase increment; other indexes are ignored. Write only while idle.
// Pipeline: the accept edge loads the accumulator register, and the output register
//   loads from it once it has room; out_valid_o rises as the output register loads.
// Throughput: 1 beat per cycle while out_stall_i is low; the 32-bit phase add and the
//   waveform mux each take one register stage.
// Reset: phase, config registers and both valid flags clear, not the output data;
//   the first tick after reset gives phase = increment.
// Stall: a stalled output holds its beat; one more beat is taken into the
//   accumulator stage, after which in_stall_o rises until the output drains.
module phase_accumulator_waveform_gen
  import pawg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                sync_reset_i,
  input  logic                block_end_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SampleW-1:0]  sample_o,
  output logic                block_end_out_o
);

  cfg_t  cfg;
  beat_t beat;
  logic  beat_valid;
  logic  take;
  logic  in_ready;

  pawg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pawg_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready),
    .sync_reset_i   (sync_reset_i),
    .block_end_in_i (block_end_in_i),
    .phase_step_i   (cfg.phase_step),
    .take_i         (take),
    .beat_valid_o   (beat_valid),
    .beat_o         (beat)
  );

  pawg_shaper u_shaper (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_valid_i    (beat_valid),
    .beat_i          (beat),
    .cfg_i           (cfg),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_o        (sample_o),
    .block_end_out_o (block_end_out_o)
  );

  assign in_stall_o = !in_ready;

endmodule

@@ rtl/pawg_checker.sv @@
// Port-level checks for the phase oscillator and their binding to the top level.
module pawg_checker
  import pawg_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                sync_reset_i,
  input logic                block_end_in_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SampleW-1:0]  sample_o,
  input logic                block_end_out_o
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o)
      && $stable(block_end_out_o))
    else $error("output beat changed while stalled");

  // Input stalls only when the output is full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // A fresh output beat comes from an input beat that passed the accumulator register
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output beat without matching input beat");

endmodule

bind phase_accumulator_waveform_gen pawg_checker u_pawg_checker (.*);

@@ tb/pawg_sample_checker.sv @@
// Sample checker for the phase oscillator: tracks config, predicts samples, compares beats.
`timescale 1ns / 100ps

module pawg_sample_checker
  import pawg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                sync_reset_i,
  input  logic                block_end_in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                block_end_out_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
  } tick_result_t;

  // Shadow copy of the oscillator registers and phase
  logic [ShapeW-1:0] shape_q     = '0;
  logic [PulseW-1:0] pulse_q     = '0;
  logic [PhaseW-1:0] incr_q      = '0;
  logic [PhaseW-1:0] osc_phase   = '0;
  tick_result_t      sample_queue[$];
  int                beat_index  = 0;

  // Shape one phase value into a sample with plain integer arithmetic
  function automatic logic signed [SampleW-1:0] render_sample(input logic [PhaseW-1:0] ph);
    longint threshold;
    int     fold;
    int     value;
    case (shape_q)
      SHAPE_SQUARE: begin
        threshold = 64'h8000_0000 + (longint'(pulse_q) << 16);
        value = (longint'(ph) < threshold) ? 32767 : -32768;
      end
      SHAPE_TRIANGLE: begin
        fold = int'(ph >> 15);
        if (fold > 65535) begin
          fold = 131071 - fold;
        end
        value = fold - 32768;
      end
      default: begin
        value = int'(ph >> 16) - 32768;
      end
    endcase
    return value[SampleW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: beat %0d mismatch: %s", $realtime, beat_index, msg);
    mismatch_count_o++;
  endtask

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      shape_q   = '0;
      pulse_q   = '0;
      incr_q    = '0;
      osc_phase = '0;
      sample_queue.delete();
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WAVE_SHAPE:  shape_q = cfg_data_i[ShapeW-1:0];
          REG_PULSE_WIDTH: pulse_q = cfg_data_i[PulseW-1:0];
          REG_PHASE_INCR:  incr_q  = cfg_data_i[PhaseW-1:0];
          default: ;
        endcase
      end

      // Advance the phase and queue the expected sample for each input beat
      if (in_valid_i && !in_stall_i) begin
        if (sync_reset_i) begin
          osc_phase = '0;
        end
        osc_phase = osc_phase + incr_q;
        want.sample    = render_sample(osc_phase);
        want.block_end = block_end_in_i;
        sample_queue.push_back(want);
      end

      // Compare each output beat with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (sample_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", $signed(sample_i)));
        end else begin
          want = sample_queue.pop_front();
          if (sample_i !== want.sample) begin
            report_mismatch($sformatf("sample got %0d expected %0d",
                                      $signed(sample_i), want.sample));
          end
          if (block_end_out_i !== want.block_end) begin
            report_mismatch($sformatf("block_end got %b expected %b",
                                      block_end_out_i, want.block_end));
          end
        end
        beat_index++;
      end
    end
    pending_o = sample_queue.size();
  end

endmodule

@@ tb/tb_phase_accumulator_waveform_gen.sv @@
// Testbench top for the phase oscillator: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_phase_accumulator_waveform_gen;
  import pawg_pkg::*;

  localparam int TickGapMax   = 17;
  localparam int HoldCycles   = 300;
  localparam int QuietLimit   = 2000;
  localparam int DrainCycles  = 4;
  localparam int TargetTicks  = 520;

  // Codes with no name in the package
  localparam logic [CfgIdxW-1:0] RegUnused   = 2'd3;
  localparam logic [ShapeW-1:0]  ShapeSawAlt = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall_o;
  logic                sync_reset;
  logic                block_end_in;
  logic                out_valid_o;
  logic                out_stall;
  logic [SampleW-1:0]  sample_o;
  logic                block_end_out_o;

  int mismatch_count;
  int pending_samples;
  int tick_count  = 0;
  int quiet_count = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;
  bit hold_req    = 1'b0;

  phase_accumulator_waveform_gen u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .sync_reset_i   (sync_reset),
    .block_end_in_i (block_end_in),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .sample_o       (sample_o),
    .block_end_out_o(block_end_out_o)
  );

  pawg_sample_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall_o),
    .sync_reset_i    (sync_reset),
    .block_end_in_i  (block_end_in),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall),
    .sample_i        (sample_o),
    .block_end_out_i (block_end_out_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_samples)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Write one register; called at a falling edge while the block is idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  // Offer one sample tick after a random gap and hold it until accepted
  task automatic send_tick(input logic sync, input logic blk);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, TickGapMax);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid     = 1'b1;
    sync_reset   = sync;
    block_end_in = blk;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    tick_count++;
  endtask

  task automatic send_random_tick();
    send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
  endtask

  // Drop valid, wait for every sample to come back, then let the pipe settle
  task automatic drain_samples();
    in_valid = 1'b0;
    while (pending_samples != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic load_random_config();
    logic [PhaseW-1:0] incr;
    logic [PulseW-1:0] pw;
    case ($urandom_range(0, 3))
      0: incr = $urandom_range(0, 32'h0010_0000);
      1: begin
        case ($urandom_range(0, 3))
          0: incr = '0;
          1: incr = 32'h0000_0001;
          2: incr = 32'h8000_0000;
          default: incr = '1;
        endcase
      end
      default: incr = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: pw = '0;
      1: pw = '1;
      default: pw = PulseW'($urandom_range(0, 32767));
    endcase
    cfg_write(REG_WAVE_SHAPE, 32'($urandom_range(0, 3)));
    cfg_write(REG_PULSE_WIDTH, 32'(pw));
    cfg_write(REG_PHASE_INCR, incr);
  endtask

  // Output side: stall a random count per beat, or hold off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = rx_burst ? 0 : $urandom_range(0, TickGapMax);
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n) @(negedge clk_i);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int n;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    sync_reset   = 1'b0;
    block_end_in = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Registers at reset value: zero increment gives the bottom of the saw
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    drain_samples();

    // Full-scale increment wraps the accumulator on each add from a nonzero phase
    cfg_write(REG_PHASE_INCR, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    drain_samples();

    // Square at zero width: switch exactly at half scale
    cfg_write(REG_WAVE_SHAPE, 32'(SHAPE_SQUARE));
    cfg_write(REG_PHASE_INCR, 32'h4000_0000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_samples();

    // Square at widest pulse: threshold sits at the top and does not wrap
    cfg_write(REG_PULSE_WIDTH, 32'h0000_7FFF);
    cfg_write(REG_PHASE_INCR, 32'hFFFF_0000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_samples();

    // Triangle at the fold point, at zero and just below the fold
    cfg_write(REG_WAVE_SHAPE, 32'(SHAPE_TRIANGLE));
    cfg_write(REG_PHASE_INCR, 32'h8000_0000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain_samples();
    cfg_write(REG_PHASE_INCR, 32'h7FFF_8000);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_samples();

    // Unused shape code falls back to saw; unused index is ignored
    cfg_write(REG_WAVE_SHAPE, 32'(ShapeSawAlt));
    cfg_write(REG_PHASE_INCR, 32'h1234_5678);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    drain_samples();
    cfg_write(RegUnused, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b1);
    drain_samples();

    // Long output hold-off while input keeps coming back to back
    load_random_config();
    tx_burst = 1'b1;
    hold_req = 1'b1;
    repeat (20) send_random_tick();
    tx_burst = 1'b0;
    drain_samples();

    // Random phases, each with fresh registers and its own idling mix
    while (tick_count < TargetTicks) begin
      load_random_config();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      repeat (n) send_random_tick();
      drain_samples();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
